// ===== hdl/ttl_pkg.sv =====
// shared types and constants of the ttl cache table
package ttl_pkg;

  localparam int KEY_IN_BITS   = 64;
  localparam int VALUE_IN_BITS = 32;
  localparam int TTL_BITS      = 16;
  localparam int TIME_BITS     = 32;
  localparam int EXPIRY_BITS   = 33;
  localparam int SLOT_BITS     = 6;
  localparam int COUNT_BITS    = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [KEY_IN_BITS-1:0]   lookup_key;
    logic [VALUE_IN_BITS-1:0] store_value;
    logic [TTL_BITS-1:0]      time_to_live;
    logic [TIME_BITS-1:0]     current_time;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic [VALUE_IN_BITS-1:0] found_value;
    logic [SLOT_BITS-1:0]     slot_used;
    logic [COUNT_BITS-1:0]    hits_total;
    logic [COUNT_BITS-1:0]    misses_total;
  } rsp_t;

  // result of one operation as the scan controller hands it over
  typedef struct packed {
    logic                     lookup;
    logic                     hit;
    logic [VALUE_IN_BITS-1:0] found_value;
    logic [SLOT_BITS-1:0]     slot_used;
  } res_t;

endpackage

// ===== hdl/ttl_chan_if.sv =====
// valid/ready channel carrying one payload type
interface ttl_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/ttl_cache_table.sv =====
// top level of the ttl cache table: slot memory, scan controller, counters, output register
//
// req (sink) carries one operation: mode 0 looks a key up, mode 1 stores
// key, value and expiry current_time + time_to_live. rsp (source) returns
// one transaction per operation with hit, found_value, slot_used and the
// saturating hit and miss counters as they stand after the operation.
// all slots live in one memory word each (valid, key, value, expiry) with
// one write port and one registered read port. the controller reads one
// slot per cycle. a store always walks every slot before it writes; a
// lookup stops at its first live match or, on a miss, after the last
// slot. expired matches are cleared during the walk. req.ready comes back
// in the cycle after the result enters the output register.
// after reset a clearing pass writes every slot invalid, one per cycle;
// req.ready stays low until it ends, and counters reset to zero.
// a finished result sits in the output register; the next req transaction
// is accepted while it waits. if rsp stalls with the register full, the
// following result is held in the controller, with req.ready low, until
// the register drains.
module ttl_cache_table #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  ttl_chan_if.sink   req,
  ttl_chan_if.source rsp
);

  localparam int IDXW      = $clog2(ENTRIES);
  localparam int WORD_BITS = 1 + KEY_BITS + VALUE_BITS + ttl_pkg::EXPIRY_BITS;

  // memory port wiring
  logic                 mem_wr_en;
  logic [IDXW-1:0]      mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [IDXW-1:0]      mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;

  // controller result handoff
  logic          res_valid;
  logic          res_ready;
  ttl_pkg::res_t res;

  // counters and output register
  logic [ttl_pkg::COUNT_BITS-1:0] hit_cnt;
  logic [ttl_pkg::COUNT_BITS-1:0] miss_cnt;
  logic [ttl_pkg::COUNT_BITS-1:0] hit_cnt_next;
  logic [ttl_pkg::COUNT_BITS-1:0] miss_cnt_next;
  logic                           out_full;
  ttl_pkg::rsp_t                  out_reg;

  ttl_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ttl_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register takes a result when empty or draining this cycle
  assign res_ready = !out_full || rsp.ready;

  // saturating counter updates, only lookups count
  always_comb begin
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    if (res.lookup && res.hit && hit_cnt != ttl_pkg::COUNT_MAX) begin
      hit_cnt_next = hit_cnt + 1'b1;
    end
    if (res.lookup && !res.hit && miss_cnt != ttl_pkg::COUNT_MAX) begin
      miss_cnt_next = miss_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
      out_full <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        hit_cnt              <= hit_cnt_next;
        miss_cnt             <= miss_cnt_next;
        out_full             <= 1'b1;
        out_reg.hit          <= res.hit;
        out_reg.found_value  <= res.found_value;
        out_reg.slot_used    <= res.slot_used;
        out_reg.hits_total   <= hit_cnt_next;
        out_reg.misses_total <= miss_cnt_next;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  assign rsp.valid   = out_full;
  assign rsp.payload = out_reg;

`ifndef SYNTH
  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hit_cnt >= $past(hit_cnt)))
    else $error("hit counter went down");

  a_misses_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (miss_cnt >= $past(miss_cnt)))
    else $error("miss counter went down");

  a_one_counter_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(hit_cnt) |-> $stable(miss_cnt))
    else $error("both counters moved in one cycle");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.hit) |-> (rsp.payload.hits_total != '0))
    else $error("hit reported with zero hit count");
`endif

endmodule

// ===== hdl/ttl_mem.sv =====
// simple dual-port slot memory, one write and one registered read per cycle
module ttl_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 130
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/ttl_ctrl.sv =====
// scan controller: clearing pass, lookup and store scans over the slot memory
module ttl_ctrl #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32,
  parameter int WORD_BITS  = 1 + KEY_BITS + VALUE_BITS + ttl_pkg::EXPIRY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  ttl_chan_if.sink                   req,
  output logic                       mem_wr_en,
  output logic [$clog2(ENTRIES)-1:0] mem_wr_addr,
  output logic [WORD_BITS-1:0]       mem_wr_data,
  output logic                       mem_rd_en,
  output logic [$clog2(ENTRIES)-1:0] mem_rd_addr,
  input  logic [WORD_BITS-1:0]       mem_rd_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ttl_pkg::res_t              res
);

  localparam int IDXW    = $clog2(ENTRIES);
  localparam int EXP_LO  = 0;
  localparam int VAL_LO  = ttl_pkg::EXPIRY_BITS;
  localparam int KEY_LO  = VAL_LO + VALUE_BITS;
  localparam int VLD_POS = KEY_LO + KEY_BITS;
  localparam logic [IDXW-1:0] LAST    = IDXW'(ENTRIES - 1);
  localparam logic [IDXW:0]   CNT_END = (IDXW + 1)'(ENTRIES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [IDXW-1:0]                 clr_idx;
  logic [IDXW:0]                   issue_cnt;
  logic                            pend;
  logic [IDXW-1:0]                 pend_idx;
  logic                            op_mode;
  logic [KEY_BITS-1:0]             op_key;
  logic [VALUE_BITS-1:0]           op_value;
  logic [ttl_pkg::EXPIRY_BITS-1:0] op_expiry;
  logic [ttl_pkg::EXPIRY_BITS-1:0] op_now;
  logic                            free_found;
  logic [IDXW-1:0]                 pick;
  logic [ttl_pkg::EXPIRY_BITS-1:0] min_exp;

  logic                            row_valid;
  logic [KEY_BITS-1:0]             row_key;
  logic [VALUE_BITS-1:0]           row_value;
  logic [ttl_pkg::EXPIRY_BITS-1:0] row_exp;
  logic                            row_match;
  logic                            row_expired;
  logic [VALUE_BITS+31:0]          val_in_ext;
  logic [VALUE_BITS+31:0]          val_out_ext;
  logic [IDXW+5:0]                 pend_slot_ext;
  logic [IDXW+5:0]                 pick_slot_ext;

  assign row_valid   = mem_rd_data[VLD_POS];
  assign row_key     = mem_rd_data[KEY_LO +: KEY_BITS];
  assign row_value   = mem_rd_data[VAL_LO +: VALUE_BITS];
  assign row_exp     = mem_rd_data[EXP_LO +: ttl_pkg::EXPIRY_BITS];
  assign row_match   = pend && row_valid && (row_key == op_key);
  assign row_expired = op_now > row_exp;

  assign val_in_ext    = {{VALUE_BITS{1'b0}}, req.payload.store_value};
  assign val_out_ext   = {32'd0, row_value};
  assign pend_slot_ext = {6'd0, pend_idx};
  assign pick_slot_ext = {6'd0, pick};

  assign req.ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // memory port control
  always_comb begin
    mem_rd_en   = (state == ST_SCAN) && (issue_cnt != CNT_END);
    mem_rd_addr = issue_cnt[IDXW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = pend_idx;
    mem_wr_data = '0;
    case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx;
      end
      ST_SCAN: begin
        // lookup drops an expired match in place
        mem_wr_en   = (op_mode == ttl_pkg::MODE_LOOKUP) && row_match && row_expired;
        mem_wr_addr = pend_idx;
        mem_wr_data = mem_rd_data;
        mem_wr_data[VLD_POS] = 1'b0;
      end
      ST_WRITE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pick;
        mem_wr_data = {1'b1, op_key, op_value, op_expiry};
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      issue_cnt <= '0;
      pend      <= 1'b0;
    end else begin
      pend     <= mem_rd_en;
      pend_idx <= issue_cnt[IDXW-1:0];
      if (mem_rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            op_mode    <= req.payload.mode;
            op_key     <= req.payload.lookup_key[KEY_BITS-1:0];
            op_value   <= val_in_ext[VALUE_BITS-1:0];
            op_expiry  <= ttl_pkg::EXPIRY_BITS'(req.payload.current_time)
                        + ttl_pkg::EXPIRY_BITS'(req.payload.time_to_live);
            op_now     <= ttl_pkg::EXPIRY_BITS'(req.payload.current_time);
            issue_cnt  <= '0;
            free_found <= 1'b0;
            pick       <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend) begin
            if (op_mode == ttl_pkg::MODE_LOOKUP) begin
              if (row_match && !row_expired) begin
                res.lookup      <= 1'b1;
                res.hit         <= 1'b1;
                res.found_value <= val_out_ext[31:0];
                res.slot_used   <= pend_slot_ext[5:0];
                state           <= ST_DONE;
              end else if (pend_idx == LAST) begin
                res.lookup      <= 1'b1;
                res.hit         <= 1'b0;
                res.found_value <= '0;
                res.slot_used   <= '0;
                state           <= ST_DONE;
              end
            end else begin
              // lowest free slot wins, else earliest expiry with lowest index
              if (!free_found) begin
                if (!row_valid) begin
                  free_found <= 1'b1;
                  pick       <= pend_idx;
                end else if ((pend_idx == '0) || (row_exp < min_exp)) begin
                  min_exp <= row_exp;
                  pick    <= pend_idx;
                end
              end
              if (pend_idx == LAST) begin
                state <= ST_WRITE;
              end
            end
          end
        end
        ST_WRITE: begin
          res.lookup      <= 1'b0;
          res.hit         <= 1'b0;
          res.found_value <= '0;
          res.slot_used   <= pick_slot_ext[5:0];
          state           <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("read and write hit the same slot");

  a_scan_write_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && mem_wr_en) |-> (!mem_wr_data[VLD_POS] && op_mode == ttl_pkg::MODE_LOOKUP))
    else $error("scan write does not invalidate");

  a_store_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (mem_wr_en && mem_wr_data[VLD_POS] && op_mode == ttl_pkg::MODE_STORE))
    else $error("store write malformed");

  a_hit_is_lookup: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.hit) |-> res.lookup)
    else $error("hit reported for a store");
`endif

endmodule
